### hdl/bbs_pkg.sv
// Package for the mesh bounding box and sphere block.
// Holds the field widths, result kind codes, the lane control struct and the
// sequencer state type. No dependencies.
`default_nettype none

package bbs_pkg;

    localparam int POS_W  = 32;
    localparam int HALF_W = 31;
    localparam int SQ_W   = 2 * HALF_W;
    localparam int SUM_W  = 64;
    localparam int RAD_W  = 32;

    localparam logic BOX_SUBSET = 1'b0;
    localparam logic BOX_MODEL  = 1'b1;

    typedef struct packed {
        logic upd;
        logic end_sub;
        logic end_mod;
        logic calc;
        logic kind;
    } t_lane_ctrl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC_SUB,
        S_EMIT_SUB,
        S_CALC_MOD,
        S_SQUARE,
        S_SUM_A,
        S_SUM_B,
        S_START,
        S_ROOT,
        S_EMIT_MOD
    } t_state;

endpackage

`default_nettype wire

### hdl/bbs_if.sv
// Valid/ready channel interfaces: vertex input beats and box result beats.
// Depends on bbs_pkg for the field widths.
`default_nettype none

interface bbs_vtx_if import bbs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    end_of_subset;
    logic                    end_of_model;

    modport source (output valid, pos_x, pos_y, pos_z, end_of_subset, end_of_model,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, end_of_subset, end_of_model,
                  output ready);
endinterface

interface bbs_box_if import bbs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    box_kind;
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic signed [POS_W-1:0] center_z;
    logic [HALF_W-1:0]       half_size_x;
    logic [HALF_W-1:0]       half_size_y;
    logic [HALF_W-1:0]       half_size_z;
    logic [RAD_W-1:0]        radius;
    logic                    final_res;

    modport source (output valid, box_kind, center_x, center_y, center_z,
                    half_size_x, half_size_y, half_size_z, radius, final_res,
                    input ready);
    modport sink (input valid, box_kind, center_x, center_y, center_z,
                  half_size_x, half_size_y, half_size_z, radius, final_res,
                  output ready);
endinterface

`default_nettype wire

### hdl/bbs_lane.sv
// One axis lane: running subset and model minimum and maximum, snapshots of
// closed boxes, and the registered center and half size of a chosen snapshot.
// Depends on bbs_pkg.
`default_nettype none

module bbs_lane import bbs_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_lane_ctrl                   i_ctrl,
    input  wire logic [POS_W-1:0]             i_pos,
    output logic signed [COORD_BITS-1:0]      o_center,
    output logic [COORD_BITS-1:0]             o_half
);

    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] r_part_lo, r_part_hi, r_whole_lo, r_whole_hi;
    logic signed [COORD_BITS-1:0] r_snap_part_lo, r_snap_part_hi;
    logic signed [COORD_BITS-1:0] r_snap_whole_lo, r_snap_whole_hi;
    logic signed [COORD_BITS-1:0] r_center;
    logic [COORD_BITS-1:0]        r_half;

    logic signed [COORD_BITS-1:0] w_pos;
    logic signed [COORD_BITS-1:0] n_part_lo, n_part_hi, n_whole_lo, n_whole_hi;
    logic signed [COORD_BITS-1:0] w_sel_lo, w_sel_hi;
    logic signed [COORD_BITS:0]   w_sum;
    logic signed [COORD_BITS:0]   w_diff;

    always_comb begin
        w_pos      = signed'(i_pos[COORD_BITS-1:0]);
        n_part_lo  = (w_pos < r_part_lo)  ? w_pos : r_part_lo;
        n_part_hi  = (w_pos > r_part_hi)  ? w_pos : r_part_hi;
        n_whole_lo = (w_pos < r_whole_lo) ? w_pos : r_whole_lo;
        n_whole_hi = (w_pos > r_whole_hi) ? w_pos : r_whole_hi;
        w_sel_lo   = (i_ctrl.kind == BOX_MODEL) ? r_snap_whole_lo : r_snap_part_lo;
        w_sel_hi   = (i_ctrl.kind == BOX_MODEL) ? r_snap_whole_hi : r_snap_part_hi;
        w_sum      = {w_sel_lo[COORD_BITS-1], w_sel_lo} + {w_sel_hi[COORD_BITS-1], w_sel_hi};
        w_diff     = {w_sel_hi[COORD_BITS-1], w_sel_hi} - {w_sel_lo[COORD_BITS-1], w_sel_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_lo  <= C_MAX;
            r_part_hi  <= C_MIN;
            r_whole_lo <= C_MAX;
            r_whole_hi <= C_MIN;
        end else if (i_ctrl.upd) begin
            if (i_ctrl.end_sub) begin
                r_part_lo <= C_MAX;
                r_part_hi <= C_MIN;
            end else begin
                r_part_lo <= n_part_lo;
                r_part_hi <= n_part_hi;
            end
            if (i_ctrl.end_mod) begin
                r_whole_lo <= C_MAX;
                r_whole_hi <= C_MIN;
            end else begin
                r_whole_lo <= n_whole_lo;
                r_whole_hi <= n_whole_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.upd && i_ctrl.end_sub) begin
            r_snap_part_lo <= n_part_lo;
            r_snap_part_hi <= n_part_hi;
        end
        if (i_ctrl.upd && i_ctrl.end_mod) begin
            r_snap_whole_lo <= n_whole_lo;
            r_snap_whole_hi <= n_whole_hi;
        end
        if (i_ctrl.calc) begin
            r_center <= w_sum[COORD_BITS:1];
            r_half   <= w_diff[COORD_BITS:1];
        end
    end

    assign o_center = r_center;
    assign o_half   = r_half;

endmodule

`default_nettype wire

### hdl/bbs_sqrt.sv
// Iterative floor square root, one root bit per cycle, of the summed squared
// half sizes. Depends on bbs_pkg for the operand and root widths.
`default_nettype none

module bbs_sqrt import bbs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_radicand,
    output logic                  o_done,
    output logic [RAD_W-1:0]      o_root
);

    localparam int CNT_W = $clog2(RAD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RAD_W - 1);

    logic [SUM_W-1:0] r_rad;
    logic [RAD_W:0]   r_rem;
    logic [RAD_W-1:0] r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [RAD_W+2:0] w_rem_sh;
    logic [RAD_W+2:0] w_trial;
    logic             w_fit;
    logic [RAD_W+2:0] w_rem_sub;

    always_comb begin
        w_rem_sh  = {r_rem, r_rad[SUM_W-1:SUM_W-2]};
        w_trial   = {1'b0, r_root, 2'b01};
        w_fit     = (w_rem_sh >= w_trial);
        w_rem_sub = w_rem_sh - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[SUM_W-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= w_rem_sub[RAD_W:0];
                r_root <= {r_root[RAD_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[RAD_W:0];
                r_root <= {r_root[RAD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

### hdl/mesh_bounding_box_and_sphere.sv
// Mesh bounding box and sphere: three axis lanes track subset and model ranges.
// Vertices that close nothing stream at one per cycle in S_IDLE. A subset-closing vertex stalls
// the input while the lanes compute its box (S_CALC_SUB) and the box waits in S_EMIT_SUB for a
// free output register. A model-closing vertex also stalls the input through squaring, summing
// and the 32-step square root; the model box follows the subset box. Reset is synchronous and
// active low and empties all ranges at once. Depends on bbs_pkg, bbs_if, bbs_lane and bbs_sqrt.
`default_nettype none

module mesh_bounding_box_and_sphere import bbs_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bbs_vtx_if.sink     i_vtx,
    bbs_box_if.source   o_box
);

    t_state r_state, n_state;
    logic   r_mod_pend;

    logic                         r_out_valid;
    logic                         r_box_kind;
    logic signed [POS_W-1:0]      r_center [3];
    logic [HALF_W-1:0]            r_half [3];
    logic [RAD_W-1:0]             r_radius;
    logic                         r_final;

    logic [SQ_W-1:0]              r_sq [3];
    logic [SUM_W-1:0]             r_sum;

    t_lane_ctrl                   w_ctrl;
    logic signed [COORD_BITS-1:0] w_lane_center [3];
    logic [COORD_BITS-1:0]        w_lane_half [3];
    logic [HALF_W-1:0]            w_half [3];
    logic [SQ_W-1:0]              w_prod [3];
    logic [POS_W-1:0]             w_pos [3];

    logic w_in_ready, w_accept, w_out_free, w_load, w_load_kind, w_load_final;
    logic w_start, w_done;
    logic [RAD_W-1:0] w_root;

    assign w_pos[0] = i_vtx.pos_x;
    assign w_pos[1] = i_vtx.pos_y;
    assign w_pos[2] = i_vtx.pos_z;

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            bbs_lane #(
                .COORD_BITS(COORD_BITS)
            ) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_pos   (w_pos[g]),
                .o_center(w_lane_center[g]),
                .o_half  (w_lane_half[g])
            );
            assign w_half[g] = HALF_W'(w_lane_half[g]);
            assign w_prod[g] = w_half[g] * w_half[g];
        end
    endgenerate

    bbs_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_radicand(r_sum),
        .o_done    (w_done),
        .o_root    (w_root)
    );

    assign w_accept   = i_vtx.valid && w_in_ready;
    assign w_out_free = !r_out_valid || o_box.ready;

    always_comb begin
        n_state      = r_state;
        w_in_ready   = 1'b0;
        w_ctrl       = '0;
        w_load       = 1'b0;
        w_load_kind  = BOX_SUBSET;
        w_load_final = 1'b1;
        w_start      = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready     = 1'b1;
                w_ctrl.upd     = i_vtx.valid;
                w_ctrl.end_sub = i_vtx.end_of_subset || i_vtx.end_of_model;
                w_ctrl.end_mod = i_vtx.end_of_model;
                if (i_vtx.valid && (i_vtx.end_of_subset || i_vtx.end_of_model)) begin
                    n_state = S_CALC_SUB;
                end
            end
            S_CALC_SUB: begin
                w_ctrl.calc = 1'b1;
                w_ctrl.kind = BOX_SUBSET;
                n_state     = S_EMIT_SUB;
            end
            S_EMIT_SUB: begin
                w_load_final = !r_mod_pend;
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = r_mod_pend ? S_CALC_MOD : S_IDLE;
                end
            end
            S_CALC_MOD: begin
                w_ctrl.calc = 1'b1;
                w_ctrl.kind = BOX_MODEL;
                n_state     = S_SQUARE;
            end
            S_SQUARE: n_state = S_SUM_A;
            S_SUM_A:  n_state = S_SUM_B;
            S_SUM_B:  n_state = S_START;
            S_START: begin
                w_start = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_done) begin
                    n_state = S_EMIT_MOD;
                end
            end
            S_EMIT_MOD: begin
                w_load_kind = BOX_MODEL;
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_mod_pend <= i_vtx.end_of_model;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_box.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_box_kind <= w_load_kind;
            r_final    <= w_load_final;
            r_radius   <= (w_load_kind == BOX_MODEL) ? w_root : '0;
            for (int a = 0; a < 3; a++) begin
                r_center[a] <= POS_W'(w_lane_center[a]);
                r_half[a]   <= w_half[a];
            end
        end
        if (r_state == S_SQUARE) begin
            for (int a = 0; a < 3; a++) begin
                r_sq[a] <= w_prod[a];
            end
        end
        if (r_state == S_SUM_A) begin
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]);
        end
        if (r_state == S_SUM_B) begin
            r_sum <= r_sum + SUM_W'(r_sq[2]);
        end
    end

    assign i_vtx.ready       = w_in_ready;
    assign o_box.valid       = r_out_valid;
    assign o_box.box_kind    = r_box_kind;
    assign o_box.center_x    = r_center[0];
    assign o_box.center_y    = r_center[1];
    assign o_box.center_z    = r_center[2];
    assign o_box.half_size_x = r_half[0];
    assign o_box.half_size_y = r_half[1];
    assign o_box.half_size_z = r_half[2];
    assign o_box.radius      = r_radius;
    assign o_box.final_res   = r_final;

    a_model_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_box_kind == BOX_MODEL)) |-> r_final)
        else $error("Model box beat without final flag.");

    a_open_subset_needs_model: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_state == S_EMIT_SUB) && !w_load_final) |=> (r_state == S_CALC_MOD))
        else $error("Non-final subset box not followed by the model box.");

    a_root_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_ROOT))
        else $error("Square root finished outside its wait state.");

    a_model_end_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_vtx.end_of_model) |=> ((r_state == S_CALC_SUB) && r_mod_pend))
        else $error("Model-closing beat did not start the box sequence.");

endmodule

`default_nettype wire
